// ===== src/bums_pkg.sv =====
// Package for the bottom-up merge sorter unit: payload structs, the sorting
// cell's link and control structs, the controller state type and constants.
// Depends on nothing.
package bums_pkg;

  localparam int VALUE_BITS = 32;
  localparam int DEPTH_DEF  = 64;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last_in;
  } bums_in_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  last_out;
    logic                  overflow;
  } bums_out_t;

  // Contents of one cell, as seen by its neighbors.
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
  } bums_slot_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                  insert;
    logic                  shift;
    logic [VALUE_BITS-1:0] new_value;
  } bums_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } bums_state_t;

endpackage

// ===== src/bottom_up_merge_sorter_unit.sv =====
// Top level of the sorter: a chain of DEPTH sorting cells and the load/emit
// controller. Depends on bums_pkg and bums_cell.
//
// Usage: present one element per cycle on in_data with start high; an
// element transfers at each edge where start is high and busy is low. While
// loading, busy stays low, so elements may follow in back-to-back cycles.
// Each element drops straight into its ascending place in the cell chain,
// so the set is already ordered when the element flagged last_in transfers.
// From the next cycle the block raises busy and emits the n held elements,
// one per cycle on out_data marked by out_strobe, smallest first, last_out
// on the final one; the receiver cannot stall, so each result is there for
// exactly one cycle. The emit rate is set by the chain shifting one
// position per cycle toward cell 0. Elements that arrive while all DEPTH
// cells are full are dropped, and every result of that set then carries
// overflow. Equal values come out adjacent in any order, which is
// indistinguishable at the ports.
module bottom_up_merge_sorter_unit #(
  parameter int DEPTH = bums_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bums_pkg::bums_in_t  in_data,
  output logic                out_strobe,
  output bums_pkg::bums_out_t out_data
);
  import bums_pkg::*;

  localparam int             CNT_W     = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  bums_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] count_after;
  bums_ctrl_t       ctrl;

  bums_slot_t       slots   [DEPTH];
  logic             gts     [DEPTH];

  // A transfer happens whenever the block is loading and start is high.
  assign accept      = start && !busy;
  assign full        = (count_r == DEPTH_CNT);
  assign count_after = full ? count_r : count_r + ONE_CNT;

  // Broadcast control: insert on a transfer with room, shift while emitting.
  assign ctrl.insert    = accept && !full;
  assign ctrl.shift     = (state_r == ST_EMIT);
  assign ctrl.new_value = in_data.value;

  // Cell chain: cell 0 holds the smallest element, empty cells trail.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    bums_slot_t left_slot, right_slot;
    logic       left_gt;

    if (gi == 0) begin : g_head
      assign left_slot = '0;
      assign left_gt   = 1'b0;
    end else begin : g_mid
      assign left_slot = slots[gi-1];
      assign left_gt   = gts[gi-1];
    end

    if (gi == DEPTH - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_body
      assign right_slot = slots[gi+1];
    end

    bums_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_slot  (left_slot),
      .left_gt    (left_gt),
      .right_slot (right_slot),
      .slot       (slots[gi]),
      .gt         (gts[gi])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_data.last_in && (count_after != '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (count_r == ONE_CNT) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Element count and overflow flag: count up while loading, down while
  // emitting; the set ends with both back at zero.
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          count_nxt = count_after;
          ovf_nxt   = ovf_r || full;
        end
      end
      ST_EMIT: begin
        count_nxt = count_r - ONE_CNT;
        if (count_r == ONE_CNT) begin
          ovf_nxt = 1'b0;
        end
      end
      default: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy       = 1'b0;
    out_strobe = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        busy       = 1'b0;
        out_strobe = 1'b0;
      end
      ST_EMIT: begin
        busy       = 1'b1;
        out_strobe = 1'b1;
      end
      default: begin
        busy       = 1'b0;
        out_strobe = 1'b0;
      end
    endcase
  end

  assign out_data.sorted_value = slots[0].value;
  assign out_data.last_out     = (count_r == ONE_CNT);
  assign out_data.overflow     = ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Every emitted result comes from an occupied head cell.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> slots[0].valid)
    else $error("emitting from an empty head cell");

  // Results of one set leave in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.last_out |=>
      out_strobe && ($signed(out_data.sorted_value) >= $signed($past(out_data.sorted_value))))
    else $error("results out of order");

  // The final result hands the block back to loading with an empty chain.
  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.last_out |=> !busy && (count_r == '0) && !slots[0].valid)
    else $error("set not cleared after final result");

  // A transfer into a full chain marks the set as overflowed.
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full |=> ovf_r)
    else $error("dropped element not flagged");

endmodule

// ===== src/bums_cell.sv =====
// One sorting cell: holds one element and its valid bit, takes the new
// element, its left neighbor's element or its right neighbor's element.
// Depends on bums_pkg.
module bums_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bums_pkg::bums_ctrl_t ctrl,
  input  bums_pkg::bums_slot_t left_slot,
  input  logic                left_gt,
  input  bums_pkg::bums_slot_t right_slot,
  output bums_pkg::bums_slot_t slot,
  output logic                gt
);
  import bums_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;

  // Empty cells count as greater, so the empty tail always opens for insertion.
  assign gt   = !valid_r || ($signed(value_r) > $signed(ctrl.new_value));
  assign slot = '{valid: valid_r, value: value_r};

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    priority if (ctrl.shift) begin
      valid_nxt = right_slot.valid;
      value_nxt = right_slot.value;
    end else if (ctrl.insert && gt && left_gt) begin
      valid_nxt = left_slot.valid;
      value_nxt = left_slot.value;
    end else if (ctrl.insert && gt) begin
      valid_nxt = 1'b1;
      value_nxt = ctrl.new_value;
    end else begin
      valid_nxt = valid_r;
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== dv/bottom_up_merge_sorter_unit_tb.sv =====
// Testbench for bottom_up_merge_sorter_unit: drives data sets over the start/busy
// command port and checks every sorted result against a predictor built in here.
// Depends on bums_pkg and the RTL of the sorter unit.
`timescale 1ns / 100ps

module bottom_up_merge_sorter_unit_tb;
  import bums_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef logic signed [VALUE_BITS-1:0] elem_t;

  // Tracks the set being loaded, predicts its sorted output and checks results.
  class sorted_set_board;
    elem_t     held[$];      // current set, kept in ascending order on arrival
    bit        dropped;      // an element of the current set did not fit
    bums_out_t sorted_due[$];
    int        mismatches;

    function new();
      dropped    = 1'b0;
      mismatches = 0;
    endfunction

    // Note one accepted element; on the last one, queue the whole sorted set.
    function void note_element(bums_in_t item);
      elem_t     v;
      int        pos;
      bums_out_t res;
      v = elem_t'(item.value);
      if (held.size() < DEPTH) begin
        // insert after every element not greater, so ties keep arrival order
        pos = held.size();
        for (int k = 0; k < held.size(); k++) begin
          if (held[k] > v) begin
            pos = k;
            break;
          end
        end
        held.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (item.last_in) begin
        for (int k = 0; k < held.size(); k++) begin
          res.sorted_value = held[k];
          res.last_out     = (k == held.size() - 1);
          res.overflow     = dropped;
          sorted_due.push_back(res);
        end
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void flag_error(string what, bums_out_t exp_r, bums_out_t act_r);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ERROR %s: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                 $time, what, $signed(exp_r.sorted_value), exp_r.last_out, exp_r.overflow,
                 $signed(act_r.sorted_value), act_r.last_out, act_r.overflow);
    endfunction

    // Compare one result with the oldest expectation.
    function void check_sorted(bums_out_t act_r);
      bums_out_t exp_r;
      if (sorted_due.size() == 0) begin
        flag_error("unexpected result", '0, act_r);
        return;
      end
      exp_r = sorted_due.pop_front();
      if (exp_r.sorted_value !== act_r.sorted_value || exp_r.last_out !== act_r.last_out ||
          exp_r.overflow !== act_r.overflow)
        flag_error("result mismatch", exp_r, act_r);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  bums_in_t  in_data;
  logic      out_strobe;
  bums_out_t out_data;

  sorted_set_board board;
  int              sent_count;

  bottom_up_merge_sorter_unit #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or never drains.
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Sample both channels at the edge, before the block's own updates land.
  // Check results ahead of noting inputs so a transfer on the same edge cannot
  // disturb the queue order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        board.check_sorted(out_data);
      if (start && !busy)
        board.note_element(in_data);
    end
  end

  // Pick an element value: mostly full-range random, with extremes and a
  // narrow band that produces plenty of ties.
  function automatic elem_t pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(VALUE_BITS-1){1'b0}}};
          1:       return {1'b0, {(VALUE_BITS-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return elem_t'($signed($urandom_range(0, 7)) - 4);
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Present one element and hold it until it transfers. Idle cycles go in
  // first, at the given chance per cycle; start stays high between
  // back-to-back elements.
  task automatic send_element(input elem_t v, input logic last, input int idle_pct);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= bums_in_t'({$urandom, 1'($urandom)});
      @(posedge clk);
    end
    start           <= 1'b1;
    in_data.value   <= v;
    in_data.last_in <= last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    sent_count++;
  endtask

  // Send a set of n random elements, last flag on the final one.
  task automatic send_random_set(input int n, input int idle_pct);
    for (int k = 0; k < n; k++)
      send_element(pick_value(), k == n - 1, idle_pct);
  endtask

  task automatic send_listed_set(input elem_t vals[$]);
    for (int k = 0; k < vals.size(); k++)
      send_element(vals[k], k == vals.size() - 1, 0);
  endtask

  int   phase_idle[4] = '{0, 73, 0, 23};
  int   big_size;
  int   phase_items;
  int   set_size;
  elem_t listed[$];

  initial begin
    board      = new();
    sent_count = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets: both extremes with zero and minus one, a one-element set,
    // ties, a descending set and an already ordered one.
    listed = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh80000000, 32'sh7fffffff};
    send_listed_set(listed);
    listed = '{-5};
    send_listed_set(listed);
    listed = '{3, 3, -3, 3, 0};
    send_listed_set(listed);
    listed = '{100, 50, -50, -100};
    send_listed_set(listed);
    listed = '{-7, -2, 0, 9, 11};
    send_listed_set(listed);

    // Random part, one phase per idling profile. Each phase opens with a large
    // set: exactly full, full plus the last element dropped, well past full,
    // then a partly full one. Small sets fill the rest.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       big_size = DEPTH;
        1:       big_size = DEPTH + 1;
        2:       big_size = $urandom_range(DEPTH + 2, DEPTH + 8);
        default: big_size = $urandom_range(20, DEPTH - 1);
      endcase
      send_random_set(big_size, phase_idle[p]);
      phase_items = 0;
      while (phase_items < 12) begin
        set_size = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
        send_random_set(set_size, phase_idle[p]);
        phase_items += set_size;
      end
    end

    // Drop start and let every queued result come out, then keep watching for
    // any stray strobe.
    start <= 1'b0;
    while (board.sorted_due.size() != 0)
      @(posedge clk);
    repeat (DEPTH + 10) @(posedge clk);

    if (board.mismatches == 0 && board.sorted_due.size() == 0 && board.held.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bums_pkg.sv
src/bums_cell.sv
src/bottom_up_merge_sorter_unit.sv
dv/bottom_up_merge_sorter_unit_tb.sv
